// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
// With SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define RVQC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define RVQC_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) trig |=> cons) else $error(msg);
`else
`define RVQC_ASSERT(lbl, clk, rstn, prop, msg)
`define RVQC_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg)
`endif
`endif

// ----- design/rvqc_pkg.sv -----
// ----------------------------------------------------------------------------
// rvqc_pkg
// Types, constants and elaboration-time helpers of the rotation vector to
// quaternion datapath.
// ----------------------------------------------------------------------------
package rvqc_pkg;

	localparam int DW   = 40;
	localparam int FRAC = 28;
	localparam int QW   = 36;

	localparam int MODE_VEC = 0;
	localparam int MODE_ROT = 1;
	localparam int MODE_DIV = 2;

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [QW-1:0] qv_t;
	typedef logic signed [15:0]   fx16_t;

	localparam dat_t PI_Q28      = 40'sd843314857;
	localparam dat_t HALF_PI_Q28 = 40'sd421657428;
	localparam dat_t TWO_PI_Q28  = 40'sd1686629713;
	localparam dat_t ONE_Q28     = 40'sd268435456;

	localparam dat_t ATAN_TAB [0:10] = '{
		40'sd210828714, 40'sd124459457, 40'sd65760959, 40'sd33381290,
		40'sd16755422, 40'sd8385879, 40'sd4193963, 40'sd2097109,
		40'sd1048571, 40'sd524287, 40'sd262144
	};

	typedef struct packed {
		fx16_t x;
		fx16_t y;
		fx16_t z;
	} rvec_t;

	typedef struct packed {
		fx16_t w;
		fx16_t x;
		fx16_t y;
		fx16_t z;
	} quat16_t;

	typedef struct packed {
		rvec_t   rot;
		quat16_t base;
	} item_t;

	typedef struct packed {
		dat_t  theta;
		logic  below;
		item_t item;
	} norm_t;

	typedef struct packed {
		qv_t     q0;
		qv_t     q1;
		qv_t     q2;
		qv_t     q3;
		logic    below;
		quat16_t base;
	} qin_t;

	typedef struct packed {
		fx16_t w;
		fx16_t x;
		fx16_t y;
		fx16_t z;
		logic  below;
	} res_t;

	function automatic dat_t atan_q28(input int i);
		if (i < 11)
			return ATAN_TAB[i[3:0]];
		return 40'sd1 <<< (FRAC - i);
	endfunction

	function automatic dat_t step_q28(input int i);
		return 40'sd1 <<< (FRAC - i);
	endfunction

	// Magnitude of a Q4.12 component widened to Q28.
	function automatic dat_t abs_q28(input fx16_t v);
		dat_t w;
		w = dat_t'(v) <<< 16;
		return w[DW-1] ? -w : w;
	endfunction

	// Add half an LSB, then floor.
	function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic fx16_t sat14(input logic signed [63:0] v);
		if (v > 64'sd16384)
			return 16'sd16384;
		if (v < -64'sd16384)
			return -16'sd16384;
		return v[15:0];
	endfunction

	// Reciprocal of the CORDIC gain in Q28, worked out at elaboration with
	// bit-serial square root and long division.
	function automatic logic [63:0] inv_gain(input int stg);
		logic [63:0] kk;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bv;
		logic [63:0] num;
		logic [63:0] quo;
		logic [64:0] r;
		int i;
		kk = 64'd1 << 60;
		for (i = 0; i < 28; i++)
			if (i < stg)
				kk = kk + (kk >> (2 * i));
		n = kk;
		res = '0;
		bv = 64'd1 << 62;
		for (i = 0; i < 32; i++)
			if (bv > n)
				bv = bv >> 2;
		for (i = 0; i < 32; i++)
			if (bv != 64'd0) begin
				if (n >= res + bv) begin
					n = n - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
		num = (64'd1 << 58) + (res >> 1);
		r = '0;
		quo = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, res}) begin
				r = r - {1'b0, res};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

endpackage

// ----- design/rvqc_if.sv -----
// ----------------------------------------------------------------------------
// rvqc_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface rvqc_in_if;
	logic valid;
	logic ready;
	rvqc_pkg::fx16_t rot_x;
	rvqc_pkg::fx16_t rot_y;
	rvqc_pkg::fx16_t rot_z;
	rvqc_pkg::fx16_t base_w;
	rvqc_pkg::fx16_t base_x;
	rvqc_pkg::fx16_t base_y;
	rvqc_pkg::fx16_t base_z;
	modport source(output valid, rot_x, rot_y, rot_z, base_w, base_x, base_y, base_z,
		input ready);
	modport sink(input valid, rot_x, rot_y, rot_z, base_w, base_x, base_y, base_z,
		output ready);
endinterface

interface rvqc_out_if;
	logic valid;
	logic ready;
	rvqc_pkg::fx16_t res_w;
	rvqc_pkg::fx16_t res_x;
	rvqc_pkg::fx16_t res_y;
	rvqc_pkg::fx16_t res_z;
	logic below_tolerance;
	modport source(output valid, res_w, res_x, res_y, res_z, below_tolerance,
		input ready);
	modport sink(input valid, res_w, res_x, res_y, res_z, below_tolerance,
		output ready);
endinterface

// ----- design/rvqc_pipe_reg.sv -----
// ----------------------------------------------------------------------------
// rvqc_pipe_reg
// One pipeline register with valid/ready; it fills bubbles and holds a word
// while the next stage is stalled.
// ----------------------------------------------------------------------------
module rvqc_pipe_reg #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         valid_s1;
	logic [W-1:0] data_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= in_data;
	end

endmodule

// ----- design/rvqc_cordic.sv -----
// ----------------------------------------------------------------------------
// rvqc_cordic
// Unrolled CORDIC, one micro-rotation per register stage, in vectoring,
// rotation or linear division mode. A side word travels with each item.
// ----------------------------------------------------------------------------
module rvqc_cordic #(
	parameter int MODE   = 0,
	parameter int STAGES = 16,
	parameter int SW     = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rvqc_pkg::dat_t in_x,
	input  rvqc_pkg::dat_t in_y,
	input  rvqc_pkg::dat_t in_z,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	input  logic           out_ready,
	output rvqc_pkg::dat_t out_x,
	output rvqc_pkg::dat_t out_y,
	output rvqc_pkg::dat_t out_z,
	output logic [SW-1:0]  out_side
);

	localparam int DW = rvqc_pkg::DW;
	localparam int RW = 3 * DW + SW;

	rvqc_pkg::dat_t xs [STAGES+1];
	rvqc_pkg::dat_t ys [STAGES+1];
	rvqc_pkg::dat_t zs [STAGES+1];
	logic [SW-1:0]  ss [STAGES+1];
	logic           vs [STAGES+1];
	logic           rs [STAGES+1];

	assign xs[0]     = in_x;
	assign ys[0]     = in_y;
	assign zs[0]     = in_z;
	assign ss[0]     = in_side;
	assign vs[0]     = in_valid;
	assign in_ready  = rs[0];
	assign out_x     = xs[STAGES];
	assign out_y     = ys[STAGES];
	assign out_z     = zs[STAGES];
	assign out_side  = ss[STAGES];
	assign out_valid = vs[STAGES];
	assign rs[STAGES] = out_ready;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		localparam rvqc_pkg::dat_t ANG  = rvqc_pkg::atan_q28(g);
		localparam rvqc_pkg::dat_t STEP = rvqc_pkg::step_q28(g);
		rvqc_pkg::dat_t nx;
		rvqc_pkg::dat_t ny;
		rvqc_pkg::dat_t nz;
		logic [RW-1:0]  d_in;
		logic [RW-1:0]  d_out;

		always_comb begin
			unique case (MODE)
				rvqc_pkg::MODE_VEC: begin
					nz = zs[g];
					if (!ys[g][DW-1]) begin
						nx = xs[g] + (ys[g] >>> g);
						ny = ys[g] - (xs[g] >>> g);
					end else begin
						nx = xs[g] - (ys[g] >>> g);
						ny = ys[g] + (xs[g] >>> g);
					end
				end
				rvqc_pkg::MODE_ROT: begin
					if (!zs[g][DW-1]) begin
						nx = xs[g] - (ys[g] >>> g);
						ny = ys[g] + (xs[g] >>> g);
						nz = zs[g] - ANG;
					end else begin
						nx = xs[g] + (ys[g] >>> g);
						ny = ys[g] - (xs[g] >>> g);
						nz = zs[g] + ANG;
					end
				end
				default: begin
					// Linear mode: y is the remainder, z the quotient.
					nx = xs[g];
					if (!ys[g][DW-1]) begin
						ny = ys[g] - (xs[g] >>> g);
						nz = zs[g] + STEP;
					end else begin
						ny = ys[g] + (xs[g] >>> g);
						nz = zs[g] - STEP;
					end
				end
			endcase
		end

		assign d_in = {nx, ny, nz, ss[g]};

		rvqc_pipe_reg #(.W(RW)) u_reg (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vs[g]),
			.in_ready  (rs[g]),
			.in_data   (d_in),
			.out_valid (vs[g+1]),
			.out_ready (rs[g+1]),
			.out_data  (d_out)
		);

		assign xs[g+1] = d_out[RW-1 -: DW];
		assign ys[g+1] = d_out[RW-DW-1 -: DW];
		assign zs[g+1] = d_out[SW+DW-1 -: DW];
		assign ss[g+1] = d_out[SW-1:0];
	end

endmodule

// ----- design/rvqc_norm.sv -----
// ----------------------------------------------------------------------------
// rvqc_norm
// Norm of the rotation vector by two vectoring CORDIC passes with gain
// correction, and the compare against the tolerance.
// ----------------------------------------------------------------------------
module rvqc_norm #(
	parameter int STAGES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [11:0]     tol,
	input  logic            in_valid,
	output logic            in_ready,
	input  rvqc_pkg::item_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rvqc_pkg::norm_t out_data
);

	localparam int DW = rvqc_pkg::DW;
	localparam int IW = $bits(rvqc_pkg::item_t);
	localparam logic [63:0] IK64 = rvqc_pkg::inv_gain(STAGES);
	localparam logic signed [29:0] IK30 = IK64[29:0];

	typedef struct packed {
		logic signed [63:0] p;
		rvqc_pkg::item_t    item;
	} mul_t;

	rvqc_pkg::dat_t  c1_x;
	logic [IW-1:0]   c1_side;
	logic            c1_valid;
	logic            c1_ready;
	mul_t            m1_in;
	mul_t            m1_out;
	logic            m1_valid;
	logic            m1_ready;
	logic signed [63:0] th1_w;
	rvqc_pkg::dat_t  th1;
	rvqc_pkg::item_t m1_item;
	rvqc_pkg::dat_t  c2_x;
	logic [IW-1:0]   c2_side;
	logic            c2_valid;
	logic            c2_ready;
	mul_t            m2_in;
	mul_t            m2_out;
	logic            m2_valid;
	logic            m2_ready;
	logic signed [63:0] th2_w;
	rvqc_pkg::dat_t  thr;
	rvqc_pkg::norm_t t_in;

	rvqc_cordic #(.MODE(rvqc_pkg::MODE_VEC), .STAGES(STAGES), .SW(IW)) u_vec_xy (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_x      (rvqc_pkg::abs_q28(in_data.rot.x)),
		.in_y      (rvqc_pkg::abs_q28(in_data.rot.y)),
		.in_z      ('0),
		.in_side   (in_data),
		.out_valid (c1_valid),
		.out_ready (c1_ready),
		.out_x     (c1_x),
		.out_y     (),
		.out_z     (),
		.out_side  (c1_side)
	);

	assign m1_in.p    = $signed(c1_x[34:0]) * IK30;
	assign m1_in.item = c1_side;

	rvqc_pipe_reg #(.W($bits(mul_t))) u_gain1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c1_valid),
		.in_ready  (c1_ready),
		.in_data   (m1_in),
		.out_valid (m1_valid),
		.out_ready (m1_ready),
		.out_data  (m1_out)
	);

	assign th1_w   = rvqc_pkg::rnd64(m1_out.p, rvqc_pkg::FRAC);
	assign th1     = th1_w[DW-1:0];
	assign m1_item = m1_out.item;

	rvqc_cordic #(.MODE(rvqc_pkg::MODE_VEC), .STAGES(STAGES), .SW(IW)) u_vec_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m1_valid),
		.in_ready  (m1_ready),
		.in_x      (th1),
		.in_y      (rvqc_pkg::abs_q28(m1_item.rot.z)),
		.in_z      ('0),
		.in_side   (m1_out.item),
		.out_valid (c2_valid),
		.out_ready (c2_ready),
		.out_x     (c2_x),
		.out_y     (),
		.out_z     (),
		.out_side  (c2_side)
	);

	assign m2_in.p    = $signed(c2_x[34:0]) * IK30;
	assign m2_in.item = c2_side;

	rvqc_pipe_reg #(.W($bits(mul_t))) u_gain2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c2_valid),
		.in_ready  (c2_ready),
		.in_data   (m2_in),
		.out_valid (m2_valid),
		.out_ready (m2_ready),
		.out_data  (m2_out)
	);

	// The tolerance is unsigned Q0.12; theta is Q28.
	assign th2_w = rvqc_pkg::rnd64(m2_out.p, rvqc_pkg::FRAC);
	assign thr   = {{(DW-28){1'b0}}, tol, 16'b0};

	always_comb begin
		t_in.theta = th2_w[DW-1:0];
		t_in.below = !(th2_w[DW-1:0] > thr);
		t_in.item  = m2_out.item;
	end

	rvqc_pipe_reg #(.W($bits(rvqc_pkg::norm_t))) u_theta (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m2_valid),
		.in_ready  (m2_ready),
		.in_data   (t_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- design/rvqc_expmap.sv -----
// ----------------------------------------------------------------------------
// rvqc_expmap
// Exponential map: half-angle reduction, sine and cosine by rotation CORDIC,
// sin/theta by linear CORDIC and scaling of the vector part.
// ----------------------------------------------------------------------------
module rvqc_expmap #(
	parameter int STAGES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rvqc_pkg::norm_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rvqc_pkg::qin_t  out_data
);

	localparam int DW = rvqc_pkg::DW;
	localparam int QW = rvqc_pkg::QW;
	localparam int NW = $bits(rvqc_pkg::norm_t);
	localparam logic [63:0] IK64 = rvqc_pkg::inv_gain(STAGES);
	localparam rvqc_pkg::dat_t IK = IK64[DW-1:0];

	typedef struct packed {
		logic            flip;
		rvqc_pkg::norm_t n;
	} rside_t;

	typedef struct packed {
		rvqc_pkg::dat_t a;
		rside_t         sd;
	} red_t;

	typedef struct packed {
		rvqc_pkg::dat_t  cx;
		rvqc_pkg::norm_t n;
	} dside_t;

	typedef struct packed {
		logic signed [47:0] px;
		logic signed [47:0] py;
		logic signed [47:0] pz;
		rvqc_pkg::dat_t     cx;
		logic               below;
		rvqc_pkg::quat16_t  base;
	} sc_t;

	red_t           r_in;
	red_t           r_out;
	logic           r_valid;
	logic           r_ready;
	rvqc_pkg::dat_t a0;
	rvqc_pkg::dat_t a1;
	rvqc_pkg::dat_t c_x;
	rvqc_pkg::dat_t c_y;
	rside_t         c_side;
	logic           c_valid;
	logic           c_ready;
	dside_t         d_in;
	dside_t         d_out;
	rvqc_pkg::dat_t syf;
	rvqc_pkg::dat_t f;
	logic           d_valid;
	logic           d_ready;
	sc_t            s_in;
	sc_t            s_out;
	logic           s_valid;
	logic           s_ready;
	logic signed [63:0] ex;
	logic signed [63:0] ey;
	logic signed [63:0] ez;
	rvqc_pkg::qin_t q_in;

	// Bring the half angle into [-pi/2, pi/2]; a fold by pi flips both outputs.
	always_comb begin
		a0 = in_data.theta >>> 1;
		a1 = (a0 > rvqc_pkg::PI_Q28) ? a0 - rvqc_pkg::TWO_PI_Q28 : a0;
		r_in.sd.n = in_data;
		if (a1 > rvqc_pkg::HALF_PI_Q28) begin
			r_in.a       = a1 - rvqc_pkg::PI_Q28;
			r_in.sd.flip = 1'b1;
		end else if (a1 < -rvqc_pkg::HALF_PI_Q28) begin
			r_in.a       = a1 + rvqc_pkg::PI_Q28;
			r_in.sd.flip = 1'b1;
		end else begin
			r_in.a       = a1;
			r_in.sd.flip = 1'b0;
		end
	end

	rvqc_pipe_reg #(.W($bits(red_t))) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (r_in),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_data  (r_out)
	);

	rvqc_cordic #(.MODE(rvqc_pkg::MODE_ROT), .STAGES(STAGES), .SW(NW + 1)) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.in_x      (IK),
		.in_y      ('0),
		.in_z      (r_out.a),
		.in_side   (r_out.sd),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_x     (c_x),
		.out_y     (c_y),
		.out_z     (),
		.out_side  (c_side)
	);

	always_comb begin
		d_in.n  = c_side.n;
		d_in.cx = c_side.flip ? -c_x : c_x;
		syf     = c_side.flip ? -c_y : c_y;
	end

	rvqc_cordic #(.MODE(rvqc_pkg::MODE_DIV), .STAGES(STAGES), .SW(DW + NW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_x      (c_side.n.theta),
		.in_y      (syf),
		.in_z      ('0),
		.in_side   (d_in),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_x     (),
		.out_y     (),
		.out_z     (f),
		.out_side  (d_out)
	);

	// The quotient stays below 2^29 in magnitude.
	always_comb begin
		s_in.px    = $signed(f[30:0]) * d_out.n.item.rot.x;
		s_in.py    = $signed(f[30:0]) * d_out.n.item.rot.y;
		s_in.pz    = $signed(f[30:0]) * d_out.n.item.rot.z;
		s_in.cx    = d_out.cx;
		s_in.below = d_out.n.below;
		s_in.base  = d_out.n.item.base;
	end

	rvqc_pipe_reg #(.W($bits(sc_t))) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_data   (s_in),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out_data  (s_out)
	);

	// The rotation vector is Q12 here, so Q28 rounding drops 12 bits.
	assign ex = rvqc_pkg::rnd64(64'(s_out.px), 12);
	assign ey = rvqc_pkg::rnd64(64'(s_out.py), 12);
	assign ez = rvqc_pkg::rnd64(64'(s_out.pz), 12);

	always_comb begin
		q_in.below = s_out.below;
		q_in.base  = s_out.base;
		if (s_out.below) begin
			q_in.q0 = rvqc_pkg::ONE_Q28[QW-1:0];
			q_in.q1 = '0;
			q_in.q2 = '0;
			q_in.q3 = '0;
		end else begin
			q_in.q0 = s_out.cx[QW-1:0];
			q_in.q1 = ex[QW-1:0];
			q_in.q2 = ey[QW-1:0];
			q_in.q3 = ez[QW-1:0];
		end
	end

	rvqc_pipe_reg #(.W($bits(rvqc_pkg::qin_t))) u_quat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_data   (q_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- design/rvqc_qmul.sv -----
// ----------------------------------------------------------------------------
// rvqc_qmul
// Hamilton product of the map quaternion with the base quaternion: products,
// sums, then rounding and saturation to Q1.14.
// ----------------------------------------------------------------------------
module rvqc_qmul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rvqc_pkg::qin_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rvqc_pkg::res_t out_data
);

	localparam int PW = rvqc_pkg::QW + 16;

	typedef logic signed [PW-1:0] pr_t;
	typedef logic signed [55:0]   acc_t;

	typedef struct packed {
		pr_t [15:0] p;
		logic       below;
	} prd_t;

	typedef struct packed {
		acc_t r0;
		acc_t r1;
		acc_t r2;
		acc_t r3;
		logic below;
	} sum_t;

	prd_t           p_in;
	prd_t           p_out;
	logic           p_valid;
	logic           p_ready;
	sum_t           s_in;
	sum_t           s_out;
	logic           s_valid;
	logic           s_ready;
	rvqc_pkg::qv_t  q [4];
	rvqc_pkg::fx16_t b [4];
	acc_t           pe [16];
	rvqc_pkg::res_t o_in;

	always_comb begin
		q[0] = in_data.q0;
		q[1] = in_data.q1;
		q[2] = in_data.q2;
		q[3] = in_data.q3;
		b[0] = in_data.base.w;
		b[1] = in_data.base.x;
		b[2] = in_data.base.y;
		b[3] = in_data.base.z;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				p_in.p[i*4+j] = q[i] * b[j];
		p_in.below = in_data.below;
	end

	rvqc_pipe_reg #(.W($bits(prd_t))) u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (p_in),
		.out_valid (p_valid),
		.out_ready (p_ready),
		.out_data  (p_out)
	);

	// Term k is q[k/4] * b[k%4].
	always_comb begin
		for (int k = 0; k < 16; k++)
			pe[k] = acc_t'($signed(p_out.p[k]));
		s_in.r0    = pe[0] - pe[5] - pe[10] - pe[15];
		s_in.r1    = pe[1] + pe[4] + pe[11] - pe[14];
		s_in.r2    = pe[2] + pe[8] + pe[13] - pe[7];
		s_in.r3    = pe[3] + pe[12] + pe[6] - pe[9];
		s_in.below = p_out.below;
	end

	rvqc_pipe_reg #(.W($bits(sum_t))) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.in_data   (s_in),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out_data  (s_out)
	);

	always_comb begin
		o_in.w     = rvqc_pkg::sat14(rvqc_pkg::rnd64(64'(s_out.r0), rvqc_pkg::FRAC));
		o_in.x     = rvqc_pkg::sat14(rvqc_pkg::rnd64(64'(s_out.r1), rvqc_pkg::FRAC));
		o_in.y     = rvqc_pkg::sat14(rvqc_pkg::rnd64(64'(s_out.r2), rvqc_pkg::FRAC));
		o_in.z     = rvqc_pkg::sat14(rvqc_pkg::rnd64(64'(s_out.r3), rvqc_pkg::FRAC));
		o_in.below = s_out.below;
	end

	rvqc_pipe_reg #(.W($bits(rvqc_pkg::res_t))) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_data   (o_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- design/rotvec_to_quat_compose_top.sv -----
// ----------------------------------------------------------------------------
// rotvec_to_quat_compose_top
// Rotation vector to unit quaternion by the exponential map, composed with a
// base quaternion by the Hamilton product.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  item     | in  | rot_x, rot_y, rot_z (Q4.12), base_w..base_z (Q1.14)
//  result   | out | res_w..res_z (Q1.14, saturated), below_tolerance
//  wr_en    | in  | write strobe, wr_data = zero_tolerance (unsigned Q0.12)
//
// One word is accepted per cycle unless a stall at the result has filled all
// stages. It holds four unrolled CORDIC chains of one micro-rotation per stage.
// Every stage register fills bubbles, so a stall at the result only stops
// the pipeline once all stages hold a word. Reset empties the pipeline and
// sets the tolerance to 1. No clearing pass is needed after reset.
`include "assert_macros.svh"

module rotvec_to_quat_compose_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	rvqc_in_if.sink           item,
	rvqc_out_if.source        result,
	input  logic              wr_en,
	input  logic [11:0]       wr_data
);

	logic [11:0]     tol_q;
	rvqc_pkg::item_t in_w;
	rvqc_pkg::norm_t n_w;
	logic            n_valid;
	logic            n_ready;
	rvqc_pkg::qin_t  q_w;
	logic            q_valid;
	logic            q_ready;
	rvqc_pkg::res_t  r_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= 12'd1;
		else if (wr_en)
			tol_q <= wr_data;
	end

	always_comb begin
		in_w.rot.x  = item.rot_x;
		in_w.rot.y  = item.rot_y;
		in_w.rot.z  = item.rot_z;
		in_w.base.w = item.base_w;
		in_w.base.x = item.base_x;
		in_w.base.y = item.base_y;
		in_w.base.z = item.base_z;
	end

	rvqc_norm #(.STAGES(CORDIC_STAGES)) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.tol       (tol_q),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_data   (in_w),
		.out_valid (n_valid),
		.out_ready (n_ready),
		.out_data  (n_w)
	);

	rvqc_expmap #(.STAGES(CORDIC_STAGES)) u_expmap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (n_valid),
		.in_ready  (n_ready),
		.in_data   (n_w),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_w)
	);

	rvqc_qmul u_qmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_data   (q_w),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (r_w)
	);

	assign result.res_w           = r_w.w;
	assign result.res_x           = r_w.x;
	assign result.res_y           = r_w.y;
	assign result.res_z           = r_w.z;
	assign result.below_tolerance = r_w.below;

	`RVQC_ASSERT(a_res_saturated, clk, arst_n, result.valid |-> (result.res_w <= 16'sd16384 && result.res_w >= -16'sd16384 && result.res_x <= 16'sd16384 && result.res_x >= -16'sd16384 && result.res_y <= 16'sd16384 && result.res_y >= -16'sd16384 && result.res_z <= 16'sd16384 && result.res_z >= -16'sd16384), "result word outside the Q1.14 unit range")
	`RVQC_ASSERT(a_stall_only_when_full, clk, arst_n, !item.ready |-> (result.valid && !result.ready), "input stalled while the result side is free")
	`RVQC_ASSERT_NEXT(a_cfg_write, clk, arst_n, wr_en, tol_q == $past(wr_data), "tolerance register missed a write")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Regression for rotvec_to_quat_compose_top. Each item turns a rotation vector
// into a quaternion and composes it with a base quaternion. A bit-exact
// predictor computes each expected result word when the block accepts the
// item. The checker compares every result word in order. Both channels stall
// at random, and the tolerance register steps through several settings.
// ----------------------------------------------------------------------------
module tb_top;
	typedef rvqc_pkg::fx16_t fx16_t;

	localparam int STAGES  = 16;
	localparam int LATENCY = 4 * STAGES + 9;
	localparam int QFRAC   = 28;

	typedef struct {
		fx16_t rx, ry, rz, bw, bx, by, bz;
	} rot_word_t;

	typedef struct {
		fx16_t w, x, y, z;
		logic  below;
	} quat_word_t;

	localparam longint ARCTAN [0:10] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144
	};
	localparam longint PI_FX      = 843314857;
	localparam longint HALF_PI_FX = 421657428;
	localparam longint TWO_PI_FX  = 1686629713;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [11:0] wr_data;

	rvqc_in_if  rot_ch();
	rvqc_out_if quat_ch();

	rotvec_to_quat_compose_top #(.CORDIC_STAGES(STAGES)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (rot_ch),
		.result  (quat_ch),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	rot_word_t  pending_words[$];
	quat_word_t expected_quats[$];
	rot_word_t  held_word;
	logic [11:0] tolerance;
	longint     gain_recip;
	bit         quiet;
	int         n_errors;
	int         n_issued;
	int         n_checked;
	int         in_gap;
	int         out_stall;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint round_sh(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clamp14(input longint v);
		if (v > 16384)
			return 16384;
		if (v < -16384)
			return -16384;
		return v;
	endfunction

	// Reciprocal of the CORDIC gain in Q28.
	function automatic longint calc_gain_recip();
		longint unsigned kk, n, root, bv;
		int i;
		kk = 64'd1 << 60;
		for (i = 0; i < STAGES; i++)
			kk = kk + (kk >> (2 * i));
		n = kk;
		root = 0;
		bv = 64'd1 << 62;
		while (bv > n)
			bv = bv >> 2;
		while (bv != 0) begin
			if (n >= root + bv) begin
				n = n - (root + bv);
				root = (root >> 1) + bv;
			end else begin
				root = root >> 1;
			end
			bv = bv >> 2;
		end
		return longint'(((64'd1 << 58) + (root >> 1)) / root);
	endfunction

	// Vectoring CORDIC magnitude, gain still applied.
	function automatic longint hyp_raw(input longint x0, input longint y0);
		longint x, y, nx;
		int i;
		x = x0;
		y = y0;
		for (i = 0; i < STAGES; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
			end
			x = nx;
		end
		return x;
	endfunction

	function automatic quat_word_t compose_quat(input rot_word_t w, input logic [11:0] tol);
		quat_word_t res;
		longint v[3], b[4], q[4], r[4];
		longint th, a, cx, sy, f, rem, nx, ang;
		bit flip;
		int i;
		v[0] = longint'(w.rx) * 65536;
		v[1] = longint'(w.ry) * 65536;
		v[2] = longint'(w.rz) * 65536;
		b[0] = longint'(w.bw);
		b[1] = longint'(w.bx);
		b[2] = longint'(w.by);
		b[3] = longint'(w.bz);
		th = round_sh(hyp_raw(mag(v[0]), mag(v[1])) * gain_recip, QFRAC);
		th = round_sh(hyp_raw(th, mag(v[2])) * gain_recip, QFRAC);
		res.below = !(th > (longint'(tol) << 16));
		if (res.below) begin
			q[0] = 64'sd1 <<< QFRAC;
			q[1] = 0;
			q[2] = 0;
			q[3] = 0;
		end else begin
			a = th >>> 1;
			cx = gain_recip;
			sy = 0;
			f = 0;
			flip = 0;
			if (a > PI_FX)
				a = a - TWO_PI_FX;
			// Fold the half angle into the CORDIC range and fix signs afterward.
			if (a > HALF_PI_FX) begin
				a = a - PI_FX;
				flip = 1;
			end else if (a < -HALF_PI_FX) begin
				a = a + PI_FX;
				flip = 1;
			end
			for (i = 0; i < STAGES; i++) begin
				ang = (i < 11) ? ARCTAN[i] : (64'sd1 <<< (QFRAC - i));
				if (a >= 0) begin
					nx = cx - (sy >>> i);
					sy = sy + (cx >>> i);
					a = a - ang;
				end else begin
					nx = cx + (sy >>> i);
					sy = sy - (cx >>> i);
					a = a + ang;
				end
				cx = nx;
			end
			if (flip) begin
				cx = -cx;
				sy = -sy;
			end
			rem = sy;
			for (i = 0; i < STAGES; i++) begin
				if (rem >= 0) begin
					rem = rem - (th >>> i);
					f = f + (64'sd1 <<< (QFRAC - i));
				end else begin
					rem = rem + (th >>> i);
					f = f - (64'sd1 <<< (QFRAC - i));
				end
			end
			q[0] = cx;
			for (i = 0; i < 3; i++)
				q[1 + i] = round_sh(f * v[i], QFRAC);
		end
		r[0] = q[0] * b[0] - q[1] * b[1] - q[2] * b[2] - q[3] * b[3];
		r[1] = q[0] * b[1] + b[0] * q[1] + q[2] * b[3] - q[3] * b[2];
		r[2] = q[0] * b[2] + b[0] * q[2] + q[3] * b[1] - q[1] * b[3];
		r[3] = q[0] * b[3] + b[0] * q[3] + q[1] * b[2] - q[2] * b[1];
		res.w = fx16_t'(clamp14(round_sh(r[0], QFRAC)));
		res.x = fx16_t'(clamp14(round_sh(r[1], QFRAC)));
		res.y = fx16_t'(clamp14(round_sh(r[2], QFRAC)));
		res.z = fx16_t'(clamp14(round_sh(r[3], QFRAC)));
		return res;
	endfunction

	// Input driver: a new word is presented only after the previous one went in.
	always @(posedge clk or negedge arst_n) begin
		bit holding;
		bit next_valid;
		if (!arst_n) begin
			rot_ch.valid <= 1'b0;
			rot_ch.rot_x <= '0;
			rot_ch.rot_y <= '0;
			rot_ch.rot_z <= '0;
			rot_ch.base_w <= '0;
			rot_ch.base_x <= '0;
			rot_ch.base_y <= '0;
			rot_ch.base_z <= '0;
			in_gap = 0;
		end else begin
			holding = rot_ch.valid;
			next_valid = 1'b0;
			if (rot_ch.valid && rot_ch.ready) begin
				expected_quats.push_back(compose_quat(held_word, tolerance));
				holding = 1'b0;
				if (!quiet && $urandom_range(0, 9) == 0)
					in_gap = $urandom_range(1, 18);
			end
			if (!holding) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_words.size() != 0) begin
					held_word = pending_words.pop_front();
					rot_ch.rot_x <= held_word.rx;
					rot_ch.rot_y <= held_word.ry;
					rot_ch.rot_z <= held_word.rz;
					rot_ch.base_w <= held_word.bw;
					rot_ch.base_x <= held_word.bx;
					rot_ch.base_y <= held_word.by;
					rot_ch.base_z <= held_word.bz;
					next_valid = 1'b1;
				end
				rot_ch.valid <= next_valid;
			end
		end
	end

	// Result monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		quat_word_t exp_q;
		bit next_ready;
		if (!arst_n) begin
			quat_ch.ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (quat_ch.valid && quat_ch.ready) begin
				n_checked++;
				if (expected_quats.size() == 0) begin
					$error("result word with no expectation pending");
					n_errors++;
				end else begin
					exp_q = expected_quats.pop_front();
					if (quat_ch.res_w !== exp_q.w) begin
						$error("res_w expected %0d actual %0d", exp_q.w, quat_ch.res_w);
						n_errors++;
					end
					if (quat_ch.res_x !== exp_q.x) begin
						$error("res_x expected %0d actual %0d", exp_q.x, quat_ch.res_x);
						n_errors++;
					end
					if (quat_ch.res_y !== exp_q.y) begin
						$error("res_y expected %0d actual %0d", exp_q.y, quat_ch.res_y);
						n_errors++;
					end
					if (quat_ch.res_z !== exp_q.z) begin
						$error("res_z expected %0d actual %0d", exp_q.z, quat_ch.res_z);
						n_errors++;
					end
					if (quat_ch.below_tolerance !== exp_q.below) begin
						$error("below_tolerance expected %0d actual %0d", exp_q.below,
							quat_ch.below_tolerance);
						n_errors++;
					end
				end
			end
			next_ready = 1'b1;
			if (out_stall > 0) begin
				out_stall--;
				next_ready = 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				// The cycle that starts the burst counts as its first idle cycle.
				out_stall = $urandom_range(0, 17);
				next_ready = 1'b0;
			end
			quat_ch.ready <= next_ready;
		end
	end

	task automatic add_word(input int rx, ry, rz, bw, bx, by, bz);
		rot_word_t w;
		w.rx = fx16_t'(rx);
		w.ry = fx16_t'(ry);
		w.rz = fx16_t'(rz);
		w.bw = fx16_t'(bw);
		w.bx = fx16_t'(bx);
		w.by = fx16_t'(by);
		w.bz = fx16_t'(bz);
		pending_words.push_back(w);
		n_issued++;
	endtask

	function automatic int pick_rot();
		case ($urandom_range(0, 3))
			0: return $signed(16'($urandom()));
			1: return $signed($urandom_range(0, 16)) - 8;
			default: return $signed($urandom_range(0, 16384)) - 8192;
		endcase
	endfunction

	function automatic int pick_base();
		if ($urandom_range(0, 7) == 0)
			return $signed(16'($urandom()));
		return $signed($urandom_range(0, 32768)) - 16384;
	endfunction

	task automatic add_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			add_word(pick_rot(), pick_rot(), pick_rot(),
				pick_base(), pick_base(), pick_base(), pick_base());
	endtask

	// Holds off until every issued word has come back, then lets the pipe settle.
	task automatic drain();
		while (n_checked != n_issued)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [11:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= value;
		tolerance = value;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		tolerance = 12'd1;
		quiet = 0;
		n_errors = 0;
		n_issued = 0;
		n_checked = 0;
		gain_recip = calc_gain_recip();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset tolerance.
		add_word(0, 0, 0, 16384, 0, 0, 0);
		add_word(0, 0, 0, 32767, -32768, 32767, -32768);
		add_word(1, 0, 0, 0, 16384, 0, 0);
		add_word(16, 0, 0, 16384, 0, 0, 0);
		add_word(4096, 0, 0, 16384, 0, 0, 0);
		add_word(0, -4096, 0, 0, 0, 16384, 0);
		add_word(0, 0, 6434, 11585, 11585, 0, 0);
		add_word(16384, 0, 0, 16384, 0, 0, 0);
		add_word(-16384, 12000, 0, 0, 0, 0, 16384);
		add_word(32767, 32767, 32767, 16384, 0, 0, 0);
		add_word(-32768, -32768, -32768, -16384, -16384, -16384, -16384);
		add_word(-32768, 32767, -32768, 16384, 16384, 16384, 16384);
		add_word(25736, 0, 0, 8192, -8192, 8192, -8192);
		add_word(0, 25736, 0, -1, 1, -1, 1);
		add_word(-1, -1, -1, -32768, 32767, 0, 0);
		add_word(12868, -12868, 0, 0, 0, 0, 0);
		add_random(140);
		drain();

		write_tolerance(12'd0);
		add_word(1, 0, 0, 16384, 0, 0, 0);
		add_word(0, 0, -1, 0, 0, 0, 16384);
		add_random(110);
		drain();

		write_tolerance(12'd4095);
		add_word(4095, 0, 0, 16384, 0, 0, 0);
		add_word(4096, 1, 0, 16384, 0, 0, 0);
		add_random(100);
		drain();

		write_tolerance(12'($urandom_range(2, 800)));
		add_random(100);
		drain();

		// Last stretch runs with both channels streaming.
		write_tolerance(12'd1);
		quiet = 1;
		add_random(80);
		drain();

		if (n_errors == 0 && expected_quats.size() == 0)
			$display("rotvec_to_quat_compose_top regression: pass");
		else
			$display("rotvec_to_quat_compose_top regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("rotvec_to_quat_compose_top regression: fail");
		$finish;
	end

endmodule
